>>> hdl/nlfc_pkg.sv
// Shared constants and helpers for the NMEA line framer with checksum check.
`default_nettype none

package nlfc_pkg;

  localparam int unsigned MaxLineDefault = 256;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;

  // Last three bytes of the first field, newest in the low byte.
  localparam logic [23:0] TailGga = 24'h474741;
  localparam logic [23:0] TailVtg = 24'h565447;

  localparam logic [1:0] KindOther = 2'd0;
  localparam logic [1:0] KindGga   = 2'd1;
  localparam logic [1:0] KindVtg   = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  // Decode one ASCII hex digit, either case.
  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.value = b[3:0];
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      r.value = 4'(b[2:0] + 3'd1) + 4'd8;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/nmea_line_framer_checksum_top.sv
// NMEA line framer: frames bytes into lines and checks the sentence checksum.
//
// One received byte is taken per clock cycle. All per-line state (byte count,
// running XOR, star and hex digit tracking, first-field tail) updates in the
// cycle a byte is accepted; a newline that closes a non-empty line loads the
// verdict into the result register, which presents it on the next cycle.
// The only input stall is a full result register whose transfer is stalled
// downstream. Carriage returns are dropped; a byte other than a newline
// that arrives with MAX_LINE bytes already held discards the line.
// line_length_o carries the low 9 bits of the held count.
`default_nettype none

module nmea_line_framer_checksum_top
  import nlfc_pkg::*;
#(
  parameter int unsigned MAX_LINE = MaxLineDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            checksum_ok_o,
  output logic [1:0]      sentence_kind_o,
  output logic [8:0]      line_length_o
);

  localparam int unsigned CntW = $clog2(MAX_LINE + 1);

  logic [CntW-1:0] held_q, held_d;
  logic [7:0]      xor_q, xor_d;
  logic            star_q, star_d;
  logic [1:0]      digits_q, digits_d;
  logic [3:0]      exp_hi_q, exp_hi_d;
  logic [3:0]      exp_lo_q, exp_lo_d;
  logic            bad_digit_q, bad_digit_d;
  logic            closed_q, closed_d;
  logic [23:0]     tail_q, tail_d;

  logic            out_valid_q, out_valid_d;
  logic            ok_q, ok_d;
  logic [1:0]      kind_q, kind_d;
  logic [8:0]      len_q, len_d;

  logic       accept;
  logic       is_lf;
  logic       produce;
  logic       lead_dollar;
  hex_digit_t hd;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_lf      = rx_byte_i == ChLf;
  assign produce    = accept & is_lf & (held_q != '0);
  assign lead_dollar = (held_q == '0) & (rx_byte_i == ChDollar);
  assign hd         = hex_decode(rx_byte_i);

  // Verdict, sentence kind and length for the line closed by this newline.
  always_comb begin
    if (!star_q) begin
      ok_d = 1'b1;
    end else if (digits_q != 2'd2 || bad_digit_q) begin
      ok_d = 1'b0;
    end else begin
      ok_d = xor_q == {exp_hi_q, exp_lo_q};
    end
    if (tail_q == TailGga) begin
      kind_d = KindGga;
    end else if (tail_q == TailVtg) begin
      kind_d = KindVtg;
    end else begin
      kind_d = KindOther;
    end
    len_d = 9'(held_q);
  end

  always_comb begin
    held_d      = held_q;
    xor_d       = xor_q;
    star_d      = star_q;
    digits_d    = digits_q;
    exp_hi_d    = exp_hi_q;
    exp_lo_d    = exp_lo_q;
    bad_digit_d = bad_digit_q;
    closed_d    = closed_q;
    tail_d      = tail_q;
    if (accept && rx_byte_i != ChCr) begin
      if (is_lf || held_q >= CntW'(MAX_LINE)) begin
        held_d      = '0;
        xor_d       = '0;
        star_d      = 1'b0;
        digits_d    = '0;
        exp_hi_d    = '0;
        exp_lo_d    = '0;
        bad_digit_d = 1'b0;
        closed_d    = 1'b0;
        tail_d      = '0;
      end else begin
        if (!star_q) begin
          if (rx_byte_i == ChStar) begin
            star_d = 1'b1;
          end else if (!lead_dollar) begin
            xor_d = xor_q ^ rx_byte_i;
          end
        end else if (digits_q != 2'd2) begin
          if (!hd.valid) bad_digit_d = 1'b1;
          if (digits_q == 2'd0) begin
            exp_hi_d = hd.value;
          end else begin
            exp_lo_d = hd.value;
          end
          digits_d = digits_q + 2'd1;
        end
        if (!closed_q) begin
          if (rx_byte_i == ChComma || rx_byte_i == ChStar) begin
            closed_d = 1'b1;
          end else if (!lead_dollar) begin
            tail_d = {tail_q[15:0], rx_byte_i};
          end
        end
        held_d = held_q + CntW'(1);
      end
    end
  end

  always_comb begin
    if (produce) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      xor_q       <= '0;
      star_q      <= 1'b0;
      digits_q    <= '0;
      exp_hi_q    <= '0;
      exp_lo_q    <= '0;
      bad_digit_q <= 1'b0;
      closed_q    <= 1'b0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      xor_q       <= xor_d;
      star_q      <= star_d;
      digits_q    <= digits_d;
      exp_hi_q    <= exp_hi_d;
      exp_lo_q    <= exp_lo_d;
      bad_digit_q <= bad_digit_d;
      closed_q    <= closed_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded only when a line closes.
  always_ff @(posedge clk_i) begin
    if (produce) begin
      ok_q   <= ok_d;
      kind_q <= kind_d;
      len_q  <= len_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign checksum_ok_o   = ok_q;
  assign sentence_kind_o = kind_q;
  assign line_length_o   = len_q;

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CntW'(MAX_LINE))
    else $error("held count above line limit");

  a_lf_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce |=> out_valid_q)
    else $error("closed line gave no result");

  a_no_digits_before_star: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !star_q |-> (digits_q == 2'd0 && !bad_digit_q))
    else $error("digit tracking active without star");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_q != 2'd3)
    else $error("digit count overran");

  a_empty_line_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q == '0 |-> (xor_q == '0 && !star_q && !closed_q && tail_q == '0))
    else $error("line state not cleared");

endmodule

`default_nettype wire
